>>> rtl/core/shamh_pkg.sv
`timescale 1ns / 1ps
package shamh_pkg;

  // One queued input item, with the byte count already limited to four.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  cnt;
    logic        last;
  } item_t;

  localparam logic [2:0] MaxBytes = 3'd4;
  localparam logic [7:0] PadMark  = 8'h80;

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

>>> rtl/core/shamh_front.sv
`timescale 1ns / 1ps
module shamh_front import shamh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        last_i,
  input  logic        pop_i,
  output logic        avail_o,
  output item_t       item_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;
  item_t      in_item;

  assign in_stall_o = (count_q == 2'd2);
  assign avail_o    = (count_q != 2'd0);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && avail_o;
  assign item_o     = mem_q[rd_ptr_q];

  // Counts of five to seven are treated as a full word.
  always_comb begin
    in_item.word = data_word_i;
    in_item.cnt  = (valid_bytes_i > MaxBytes) ? MaxBytes : valid_bytes_i;
    in_item.last = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_item;
  end

endmodule

>>> rtl/core/shamh_back.sv
`timescale 1ns / 1ps
module shamh_back import shamh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  item_t       item_i,
  output logic        pop_o,
  input  logic        double_hash_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic        digest_last_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ABSORB, ST_PAD, ST_LEN, ST_COMP, ST_ADD, ST_DOUBLE, ST_OUT
  } state_e;

  typedef enum logic [1:0] {POST_ABSORB, POST_LEN, POST_FINAL} post_e;

  state_e             state_q, state_d;
  post_e              post_q, post_d;
  logic [15:0][31:0]  w_q, w_d;
  logic [31:0]        h_q [8];
  logic [31:0]        h_d [8];
  logic [31:0]        v_q [8];
  logic [31:0]        v_d [8];
  logic [63:0]        bcnt_q, bcnt_d;
  logic [5:0]         fill_q, fill_d;
  logic [5:0]         rnd_q, rnd_d;
  logic               second_q, second_d;
  logic               pend_vld_q, pend_vld_d;
  logic [31:0]        pend_word_q, pend_word_d;
  logic [2:0]         pend_cnt_q, pend_cnt_d;
  logic               pend_last_q, pend_last_d;
  logic [2:0]         oidx_q, oidx_d;
  logic               ovld_q, ovld_d;
  logic [31:0]        oword_q, oword_d;
  logic               olast_q, olast_d;

  logic [6:0]  room, pos, endpos;
  logic [2:0]  n;
  logic [63:0] bits;
  logic [31:0] s0, s1, sig0, sig1, ch, maj, t1, t2, wnew;
  logic [4:0]  off;
  logic        take;

  assign pop_o         = (state_q == ST_IDLE) && avail_i;
  assign out_valid_o   = ovld_q;
  assign digest_word_o = oword_q;
  assign digest_last_o = olast_q;
  assign bits          = {bcnt_q[60:0], 3'b000};
  assign take          = !ovld_q || !out_stall_i;

  always_comb begin
    s0   = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
    s1   = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
         ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    sig1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
         ^ {v_q[4][24:0], v_q[4][31:25]};
    ch   = v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6]));
    t1   = v_q[7] + sig1 + ch + K_TAB[rnd_q] + w_q[0];
    sig0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
         ^ {v_q[0][21:0], v_q[0][31:22]};
    maj  = (v_q[0] & v_q[1]) | (v_q[2] & (v_q[0] | v_q[1]));
    t2   = sig0 + maj;
  end

  always_comb begin
    room   = 7'd64 - {1'b0, fill_q};
    n      = ({4'b0, pend_cnt_q} < room) ? pend_cnt_q : room[2:0];
    endpos = {1'b0, fill_q} + {4'b0, n};
  end

  always_comb begin
    state_d     = state_q;
    post_d      = post_q;
    w_d         = w_q;
    h_d         = h_q;
    v_d         = v_q;
    bcnt_d      = bcnt_q;
    fill_d      = fill_q;
    rnd_d       = rnd_q;
    second_d    = second_q;
    pend_vld_d  = pend_vld_q;
    pend_word_d = pend_word_q;
    pend_cnt_d  = pend_cnt_q;
    pend_last_d = pend_last_q;
    oidx_d      = oidx_q;
    ovld_d      = ovld_q;
    oword_d     = oword_q;
    olast_d     = olast_q;
    pos         = 7'd0;
    off         = 5'd0;

    case (state_q)
      ST_IDLE: begin
        if (avail_i) begin
          pend_vld_d  = 1'b1;
          pend_word_d = item_i.word;
          pend_cnt_d  = item_i.cnt;
          pend_last_d = item_i.last;
          state_d     = ST_ABSORB;
        end
      end
      ST_ABSORB: begin
        // Pack up to four bytes at the fill point, stopping at a block boundary.
        for (int i = 0; i < 4; i++) begin
          pos = {1'b0, fill_q} + 7'(i);
          off = {~pos[1:0], 3'b000};
          if (3'(i) < n) w_d[pos[5:2]][off +: 8] = pend_word_q[31 - 8*i -: 8];
        end
        fill_d      = endpos[5:0];
        bcnt_d      = bcnt_q + {61'b0, n};
        pend_word_d = pend_word_q << {n, 3'b000};
        pend_cnt_d  = pend_cnt_q - n;
        if (endpos[6]) begin
          for (int i = 0; i < 8; i++) v_d[i] = h_q[i];
          post_d  = POST_ABSORB;
          rnd_d   = 6'd0;
          state_d = ST_COMP;
        end else if (pend_last_q) begin
          pend_vld_d = 1'b0;
          state_d    = ST_PAD;
        end else begin
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      ST_PAD: begin
        for (int p = 0; p < 64; p++) begin
          if (6'(p) == fill_q) w_d[p/4][31 - 8*(p%4) -: 8] = PadMark;
          else if (6'(p) > fill_q) w_d[p/4][31 - 8*(p%4) -: 8] = 8'h00;
        end
        if (fill_q < 6'd56) begin
          w_d[14] = bits[63:32];
          w_d[15] = bits[31:0];
          post_d  = POST_FINAL;
        end else begin
          post_d  = POST_LEN;
        end
        for (int i = 0; i < 8; i++) v_d[i] = h_q[i];
        rnd_d   = 6'd0;
        state_d = ST_COMP;
      end
      ST_LEN: begin
        for (int i = 0; i < 14; i++) w_d[i] = 32'h0;
        w_d[14] = bits[63:32];
        w_d[15] = bits[31:0];
        for (int i = 0; i < 8; i++) v_d[i] = h_q[i];
        post_d  = POST_FINAL;
        rnd_d   = 6'd0;
        state_d = ST_COMP;
      end
      ST_COMP: begin
        // One round per cycle; the schedule window slides by one word.
        for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
        w_d[15] = wnew;
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = ST_ADD;
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) h_d[i] = h_q[i] + v_q[i];
        case (post_q)
          POST_ABSORB: state_d = pend_vld_q ? ST_ABSORB : ST_IDLE;
          POST_LEN:    state_d = ST_LEN;
          POST_FINAL:  state_d = (double_hash_i && !second_q) ? ST_DOUBLE : ST_OUT;
          default:     state_d = ST_IDLE;
        endcase
      end
      ST_DOUBLE: begin
        // The 32-byte first digest as a padded one-block message of 256 bits.
        for (int i = 0; i < 8; i++) begin
          w_d[i] = h_q[i];
          h_d[i] = IV_TAB[i];
          v_d[i] = IV_TAB[i];
        end
        w_d[8] = {PadMark, 24'h0};
        for (int i = 9; i < 15; i++) w_d[i] = 32'h0;
        w_d[15]  = 32'd256;
        second_d = 1'b1;
        post_d   = POST_FINAL;
        rnd_d    = 6'd0;
        state_d  = ST_COMP;
      end
      ST_OUT: begin
        if (take) begin
          ovld_d  = 1'b1;
          oword_d = h_q[oidx_q];
          olast_d = (oidx_q == 3'd7);
          oidx_d  = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            for (int i = 0; i < 8; i++) h_d[i] = IV_TAB[i];
            bcnt_d   = 64'd0;
            fill_d   = 6'd0;
            second_d = 1'b0;
            state_d  = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (state_q != ST_OUT && ovld_q && !out_stall_i) ovld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      post_q     <= POST_ABSORB;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= IV_TAB[i];
        v_q[i] <= 32'h0;
      end
      bcnt_q     <= 64'd0;
      fill_q     <= 6'd0;
      rnd_q      <= 6'd0;
      second_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      oidx_q     <= 3'd0;
      ovld_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      post_q     <= post_d;
      h_q        <= h_d;
      v_q        <= v_d;
      bcnt_q     <= bcnt_d;
      fill_q     <= fill_d;
      rnd_q      <= rnd_d;
      second_q   <= second_d;
      pend_vld_q <= pend_vld_d;
      oidx_q     <= oidx_d;
      ovld_q     <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q         <= w_d;
    pend_word_q <= pend_word_d;
    pend_cnt_q  <= pend_cnt_d;
    pend_last_q <= pend_last_d;
    oword_q     <= oword_d;
    olast_q     <= olast_d;
  end

  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP && rnd_q == 6'd63) |=> (state_q == ST_ADD))
    else $error("compression did not end after the last round");

  a_pop_absorb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == ST_ABSORB && pend_vld_q))
    else $error("popped item not absorbed");

  a_tail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_OUT && ovld_q) |-> olast_q)
    else $error("digest left output state before its final word");

  a_out_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_OUT) |-> (oidx_q == 3'd0))
    else $error("digest word index not rewound");

endmodule

>>> rtl/core/sha256_message_hasher.sv
`timescale 1ns / 1ps
// A word leaves the front queue in the idle state, then the absorb state packs its bytes.
// Each full 64-byte block then runs 64 rounds in one shared round unit and one chain
// add; the back end takes no new word from the queue while it compresses.
// The last word adds a padding block, one more block when the length needs its own block
// and one more in double mode, then 8 digest items, one per cycle when not stalled.
// Reset (asynchronous, active low) loads the initial hash, clears counts and flags
// and sets double mode off; the schedule buffer is left as is.
module sha256_message_hasher import shamh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic        digest_last_o
);

  // Double-hash mode register; user writes it only while the block is idle, unenforced.
  logic  double_hash_q;
  logic  avail, pop;
  item_t item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      double_hash_q <= 1'b0;
    end else if (cfg_we_i) begin
      double_hash_q <= cfg_wdata_i;
    end
  end

  // The front queue takes items and limits their byte count; it holds two items, so
  // the input can run that far ahead while the back end runs compression rounds.
  shamh_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_word_i   (data_word_i),
    .valid_bytes_i (valid_bytes_i),
    .last_i        (last_i),
    .pop_i         (pop),
    .avail_o       (avail),
    .item_o        (item)
  );

  // The back end packs bytes, pads, compresses and drives the output register.
  shamh_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (avail),
    .item_i        (item),
    .pop_o         (pop),
    .double_hash_i (double_hash_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digest_word_o (digest_word_o),
    .digest_last_o (digest_last_o)
  );

endmodule

>>> tb/sha256_digest_checker.sv
`timescale 1ns / 1ps
module sha256_digest_checker import shamh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] digest_word_i,
  input  logic        digest_last_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] word;
    logic        fin;
  } digest_item_t;

  logic [31:0] chain [8];
  logic [31:0] blk [16];
  logic [63:0] msg_bytes;
  logic [5:0]  fill;
  logic        dbl_mode;
  digest_item_t digest_q [$];

  assign pending_o = digest_q.size();

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] v [8];
    logic [31:0] w, s0, s1, t1, t2, a15, a2;
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        w = blk[r];
      end else begin
        a15 = blk[(r + 1) & 15];
        a2 = blk[(r + 14) & 15];
        s0 = rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3);
        s1 = rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10);
        w = blk[r & 15] + s0 + blk[(r + 9) & 15] + s1;
        blk[r & 15] = w;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + K_TAB[r] + w;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic push_byte(logic [7:0] b);
    int sh;
    sh = 24 - 8 * fill[1:0];
    blk[fill[5:2]] = (blk[fill[5:2]] & ~(32'hff << sh)) | (32'(b) << sh);
    fill = fill + 6'd1;
    if (fill == 6'd0) compress();
  endtask

  task automatic pad_out(logic [63:0] nbytes);
    logic [63:0] bits;
    bits = nbytes << 3;
    push_byte(PadMark);
    while (fill != 6'd56) push_byte(8'h00);
    for (int i = 7; i >= 0; i--) push_byte(bits[8 * i +: 8]);
  endtask

  task automatic restart();
    for (int i = 0; i < 8; i++) chain[i] = IV_TAB[i];
    msg_bytes = '0;
    fill = '0;
  endtask

  task automatic absorb_word(logic [31:0] word, logic [2:0] cnt, logic fin);
    int n;
    logic [31:0] first [8];
    n = (cnt > MaxBytes) ? 4 : int'(cnt);
    for (int i = 0; i < n; i++) begin
      push_byte(word[31 - 8 * i -: 8]);
      msg_bytes++;
    end
    if (fin) begin
      pad_out(msg_bytes);
      if (dbl_mode) begin
        first = chain;
        restart();
        for (int i = 0; i < 32; i++) push_byte(first[i >> 2][31 - 8 * (i & 3) -: 8]);
        pad_out(64'd32);
      end
      for (int i = 0; i < 8; i++) digest_q.push_back('{chain[i], i == 7});
      restart();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_item_t exp_item;
    if (!rst_ni) begin
      restart();
      dbl_mode = 1'b0;
      fail_count_o = 0;
      digest_q.delete();
    end else begin
      if (cfg_we_i) dbl_mode = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) absorb_word(data_word_i, valid_bytes_i, last_i);
      if (out_valid_i && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected digest item %h last %b", digest_word_i, digest_last_i);
        end else begin
          exp_item = digest_q.pop_front();
          if (exp_item.word !== digest_word_i || exp_item.fin !== digest_last_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("digest mismatch: expected %h/%b, got %h/%b", exp_item.word,
                       exp_item.fin, digest_word_i, digest_last_i);
          end
        end
      end
    end
  end
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the streaming SHA-256 hasher. The checker beside the
// block predicts every digest item; this module only makes traffic.
module testbench;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] data_word_i = '0;
  logic [2:0]  valid_bytes_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic        digest_last_o;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  // Idle percentages; zero during the calm stretch.
  int          send_idle = 38;
  int          recv_idle = 38;
  bit          hold_off = 1'b0;

  sha256_message_hasher dut (.*);

  sha256_digest_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_stall_i(in_stall_o), .data_word_i, .valid_bytes_i, .last_i,
    .out_valid_i(out_valid_o), .out_stall_i, .digest_word_i(digest_word_o),
    .digest_last_i(digest_last_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Generous limit: even the slowest run stays far below this.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // The receiver stalls at random, or holds off completely while hold_off is set.
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_idle);
  end

  // Offers one item and keeps it steady until the block accepts it. Idle cycles
  // come first, so valid is never dropped and raised in the same step.
  task automatic send_word(logic [31:0] word, logic [2:0] cnt, logic fin);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_word_i <= word;
    valid_bytes_i <= cnt;
    last_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Waits until every digest item has come out, then lets the block settle
  // before the mode register may change.
  task automatic drain_and_set(logic mode);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A well-formed message of n full words, then a last word of zero to four bytes.
  task automatic send_message(int n);
    for (int i = 0; i < n; i++) send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, 3'($urandom_range(4)), 1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, "abc", short and oversized counts, empty words
    // in the middle, a length that needs its own block and extreme data.
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'h61626300, 3'd3, 1'b1);
    send_word(32'hffffffff, 3'd7, 1'b0);
    send_word(32'h12345678, 3'd0, 1'b0);
    send_word(32'habcdef01, 3'd2, 1'b0);
    send_word(32'h00000000, 3'd5, 1'b0);
    send_word(32'hffffffff, 3'd1, 1'b1);
    for (int i = 0; i < 14; i++) send_word(32'hffffffff, 3'd4, 1'b0);
    send_word(32'h0, 3'd6, 1'b1);
    drain_and_set(1'b1);
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'h61626300, 3'd3, 1'b1);

    // Random traffic with the receiver held off so the block backs up.
    fork
      begin
        hold_off = 1'b1;
        repeat (1500) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int m = 0; m < 4; m++) send_message($urandom_range(3));
    join

    for (int phase = 0; phase < 4; phase++) begin
      drain_and_set(phase[0]);
      if (phase == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end else begin
        send_idle = 38;
        recv_idle = 38;
      end
      for (int m = 0; m < 8; m++) begin
        if ($urandom_range(9) == 0) begin
          send_word($urandom, 3'($urandom_range(7)), 1'b0);
          send_word($urandom, 3'($urandom_range(7)), 1'($urandom_range(1)));
        end
        send_message(($urandom_range(5) == 0) ? $urandom_range(16, 20) : $urandom_range(6));
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

>>> sha256_message_hasher.f
rtl/core/shamh_pkg.sv
rtl/core/shamh_front.sv
rtl/core/shamh_back.sv
rtl/core/sha256_message_hasher.sv
tb/sha256_digest_checker.sv
tb/testbench.sv
